[hw/rtl/tlv_record_parser_assert.svh]
// ---------------------------------------------------------------------------
// tlv_record_parser_assert.svh
// Assertion macros for the TLV record parser. Synthesis builds define SYNTH
// so that the macros expand to nothing.
// ---------------------------------------------------------------------------
`ifndef TLV_RECORD_PARSER_ASSERT_SVH
`define TLV_RECORD_PARSER_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset
`define TLV_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlv_record_parser: same-cycle check failed");
// Next-cycle implication, checked out of reset
`define TLV_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlv_record_parser: next-cycle check failed");
`else
`define TLV_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define TLV_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/tlvrp_pkg.sv]
// ---------------------------------------------------------------------------
// tlvrp_pkg
// Shared types and constants of the TLV record parser.
// ---------------------------------------------------------------------------
`default_nettype none

package tlvrp_pkg;

  // Result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_VALUE  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Command queue between parser front and output back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // Compact result request; a value byte travels in ident[7:0]
  typedef struct packed {
    logic [1:0]  kind;
    logic        last;
    logic [1:0]  ident_kind;
    logic [15:0] ident;
    logic [23:0] vlen;
    logic [23:0] off;
  } cmd_t;

endpackage

`default_nettype wire

[hw/rtl/tlvrp_front.sv]
// ---------------------------------------------------------------------------
// tlvrp_front
// Byte parser: tracks header phase, identifier, length and buffer position,
// and issues one compact result request per byte that yields a result.
// ---------------------------------------------------------------------------
`default_nettype none

module tlvrp_front #(
  parameter int POSITION_WIDTH = 24
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic [7:0]    data_byte,
  input  wire logic          buffer_end,
  output tlvrp_pkg::cmd_t    cmd,
  output logic               cmd_valid
);

  typedef enum logic [4:0] {
    PH_TYPE  = 5'b00001,
    PH_ID_HI = 5'b00010,
    PH_ID_LO = 5'b00100,
    PH_LEN   = 5'b01000,
    PH_VALUE = 5'b10000
  } phase_t;

  phase_t                    phase_r, phase_nxt;
  logic [7:0]                type_r, type_nxt;
  logic [15:0]               ident_r, ident_nxt;
  logic [23:0]               len_r, len_nxt;
  logic [1:0]                hdr_left_r, hdr_left_nxt;
  logic [23:0]               val_left_r, val_left_nxt;
  logic [POSITION_WIDTH-1:0] pos_r, pos_nxt;

  logic [POSITION_WIDTH-1:0] pos_inc;
  logic [31:0]               pos_ext;
  logic                      fin;
  logic                      err;
  logic                      hdr_emit;
  logic                      val_emit;
  logic                      val_last;

  assign pos_inc = pos_r + 1'b1;
  assign pos_ext = 32'(pos_inc);

  // Next parse state for the byte on the input
  always_comb begin
    phase_nxt    = phase_r;
    type_nxt     = type_r;
    ident_nxt    = ident_r;
    len_nxt      = len_r;
    hdr_left_nxt = hdr_left_r;
    val_left_nxt = val_left_r;
    fin          = 1'b0;
    err          = 1'b0;
    hdr_emit     = 1'b0;
    val_emit     = 1'b0;
    val_last     = 1'b0;

    case (phase_r)
      PH_TYPE: begin
        type_nxt     = data_byte;
        ident_nxt    = 16'h0000;
        len_nxt      = 24'h000000;
        val_left_nxt = 24'h000000;
        hdr_left_nxt = data_byte[4:3];
        phase_nxt    = data_byte[5] ? PH_ID_HI : PH_ID_LO;
        err          = buffer_end;
      end
      PH_ID_HI: begin
        ident_nxt = {8'h00, data_byte};
        phase_nxt = PH_ID_LO;
        err       = buffer_end;
      end
      PH_ID_LO: begin
        ident_nxt = {ident_r[7:0], data_byte};
        if (hdr_left_r == 2'd0) begin
          len_nxt = {21'd0, type_r[2:0]};
          fin     = 1'b1;
        end else begin
          phase_nxt = PH_LEN;
          err       = buffer_end;
        end
      end
      PH_LEN: begin
        len_nxt      = {len_r[15:0], data_byte};
        hdr_left_nxt = hdr_left_r - 2'd1;
        if (hdr_left_r == 2'd1) begin
          fin = 1'b1;
        end else begin
          err = buffer_end;
        end
      end
      PH_VALUE: begin
        if (val_left_r <= 24'd1) begin
          val_emit     = 1'b1;
          val_last     = 1'b1;
          val_left_nxt = 24'd0;
          phase_nxt    = PH_TYPE;
        end else if (buffer_end) begin
          err          = 1'b1;
          val_left_nxt = 24'd0;
          phase_nxt    = PH_TYPE;
        end else begin
          val_emit     = 1'b1;
          val_left_nxt = val_left_r - 24'd1;
        end
      end
      default: begin
        phase_nxt = PH_TYPE;
      end
    endcase

    // Complete the header; a nonempty value cannot follow the final byte
    if (fin) begin
      if (buffer_end && (len_nxt != 24'd0)) begin
        err       = 1'b1;
        phase_nxt = PH_TYPE;
      end else begin
        hdr_emit     = 1'b1;
        phase_nxt    = (len_nxt == 24'd0) ? PH_TYPE : PH_VALUE;
        val_left_nxt = len_nxt;
      end
    end

    // Restart on the final byte of the buffer
    if (buffer_end) begin
      phase_nxt    = PH_TYPE;
      hdr_left_nxt = 2'd0;
      val_left_nxt = 24'd0;
      pos_nxt      = '0;
    end else begin
      pos_nxt = pos_inc;
    end
  end

  // Build the result request
  always_comb begin
    cmd            = '0;
    cmd_valid      = accept && (err || hdr_emit || val_emit);
    if (err) begin
      cmd.kind = tlvrp_pkg::KIND_ERROR;
      cmd.last = 1'b1;
    end else if (hdr_emit) begin
      cmd.kind       = tlvrp_pkg::KIND_HEADER;
      cmd.last       = (len_nxt == 24'd0);
      cmd.ident_kind = type_r[7:6];
      cmd.ident      = ident_nxt;
      cmd.vlen       = len_nxt;
      cmd.off        = pos_ext[23:0];
    end else begin
      cmd.kind  = tlvrp_pkg::KIND_VALUE;
      cmd.last  = val_last;
      cmd.ident = {8'h00, data_byte};
    end
  end

  // Advance parse state on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_TYPE;
      type_r     <= 8'h00;
      ident_r    <= 16'h0000;
      len_r      <= 24'h000000;
      hdr_left_r <= 2'd0;
      val_left_r <= 24'd0;
      pos_r      <= '0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      type_r     <= type_nxt;
      ident_r    <= ident_nxt;
      len_r      <= len_nxt;
      hdr_left_r <= hdr_left_nxt;
      val_left_r <= val_left_nxt;
      pos_r      <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tlvrp_queue.sv]
// ---------------------------------------------------------------------------
// tlvrp_queue
// Short FIFO of result requests between the parser and the output stage.
// ---------------------------------------------------------------------------
`default_nettype none

module tlvrp_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_en,
  input  wire tlvrp_pkg::cmd_t wr_data,
  output logic                 q_full,
  input  wire logic            rd_en,
  output tlvrp_pkg::cmd_t      rd_data,
  output logic                 q_empty
);

  tlvrp_pkg::cmd_t                mem [tlvrp_pkg::Q_DEPTH];
  logic [tlvrp_pkg::Q_AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [tlvrp_pkg::Q_AW:0]       count_r, count_nxt;
  logic                           do_wr, do_rd;

  assign q_full  = (count_r == (tlvrp_pkg::Q_AW + 1)'(tlvrp_pkg::Q_DEPTH));
  assign q_empty = (count_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem[rd_ptr_r];

  // Track occupancy
  always_comb begin
    count_nxt = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Store requests
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tlvrp_back.sv]
// ---------------------------------------------------------------------------
// tlvrp_back
// Output stage: expands result requests into the result fields and holds
// them until popped.
// ---------------------------------------------------------------------------
`default_nettype none

module tlvrp_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_empty,
  input  wire tlvrp_pkg::cmd_t q_data,
  output logic                 q_rd,
  input  wire logic            pop,
  output logic                 empty,
  output logic [1:0]           out_kind,
  output logic [1:0]           out_ident_kind,
  output logic [15:0]          out_ident,
  output logic [23:0]          out_value_length,
  output logic [23:0]          out_value_offset,
  output logic [7:0]           out_value_byte,
  output logic                 out_record_last
);

  logic        valid_r;
  logic        load;
  logic [1:0]  ident_kind_nxt;
  logic [15:0] ident_nxt;
  logic [23:0] vlen_nxt;
  logic [23:0] off_nxt;
  logic [7:0]  vbyte_nxt;

  assign load  = !q_empty && (!valid_r || pop);
  assign q_rd  = load;
  assign empty = !valid_r;

  // Expand the request by kind
  always_comb begin
    ident_kind_nxt = 2'd0;
    ident_nxt      = 16'h0000;
    vlen_nxt       = 24'd0;
    off_nxt        = 24'd0;
    vbyte_nxt      = 8'h00;
    case (q_data.kind)
      tlvrp_pkg::KIND_HEADER: begin
        ident_kind_nxt = q_data.ident_kind;
        ident_nxt      = q_data.ident;
        vlen_nxt       = q_data.vlen;
        off_nxt        = q_data.off;
      end
      tlvrp_pkg::KIND_VALUE: begin
        vbyte_nxt = q_data.ident[7:0];
      end
      default: begin
        vbyte_nxt = 8'h00;
      end
    endcase
  end

  // Hold the result until popped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind         <= q_data.kind;
      out_record_last  <= q_data.last;
      out_ident_kind   <= ident_kind_nxt;
      out_ident        <= ident_nxt;
      out_value_length <= vlen_nxt;
      out_value_offset <= off_nxt;
      out_value_byte   <= vbyte_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tlv_record_parser.sv]
// ---------------------------------------------------------------------------
// tlv_record_parser
// Streaming OMA LwM2M TLV record decoder: takes a buffer one byte at a time
// and gives one header result per record, one result per value byte, and a
// truncation error where the buffer ends inside a record.
//
//   channel  | handshake          | payload
//   ---------+--------------------+----------------------------------------
//   input    | push / full        | in_data_byte, in_buffer_end
//   result   | empty / pop        | out_kind .. out_record_last
//
// One byte is taken per cycle while full is low; the parse state is registered
// as each byte is taken. A result reaches the result ports through the request
// queue, written as its byte is taken, and the output register, loaded once
// that register is empty or being popped.
// The four-entry request queue absorbs result stalls; full rises only when
// it holds four results, and bytes that yield no result still wait on it.
// Synchronous reset returns the parser to the type-byte phase at position 0.
// ---------------------------------------------------------------------------
`default_nettype none

module tlv_record_parser #(
  parameter int POSITION_WIDTH = 24
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_buffer_end,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       out_kind,
  output logic [1:0]       out_ident_kind,
  output logic [15:0]      out_ident,
  output logic [23:0]      out_value_length,
  output logic [23:0]      out_value_offset,
  output logic [7:0]       out_value_byte,
  output logic             out_record_last
);

`include "tlv_record_parser_assert.svh"

  tlvrp_pkg::cmd_t cmd;
  tlvrp_pkg::cmd_t q_data;
  logic            cmd_valid;
  logic            accept;
  logic            q_full;
  logic            q_empty;
  logic            q_rd;
  logic            hdr_shown;
  logic            hdr_last_ok;
  logic            err_shown;

  assign full   = q_full;
  assign accept = push && !q_full;

  // Parse bytes into result requests
  tlvrp_front #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .data_byte  (in_data_byte),
    .buffer_end (in_buffer_end),
    .cmd        (cmd),
    .cmd_valid  (cmd_valid)
  );

  // Buffer requests between the two sides
  tlvrp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_valid),
    .wr_data (cmd),
    .q_full  (q_full),
    .rd_en   (q_rd),
    .rd_data (q_data),
    .q_empty (q_empty)
  );

  // Present results
  tlvrp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_data           (q_data),
    .q_rd             (q_rd),
    .pop              (pop),
    .empty            (empty),
    .out_kind         (out_kind),
    .out_ident_kind   (out_ident_kind),
    .out_ident        (out_ident),
    .out_value_length (out_value_length),
    .out_value_offset (out_value_offset),
    .out_value_byte   (out_value_byte),
    .out_record_last  (out_record_last)
  );

  // Checks
  assign hdr_shown   = !empty && (out_kind == tlvrp_pkg::KIND_HEADER);
  assign hdr_last_ok = (out_record_last == (out_value_length == 24'd0));
  assign err_shown   = !empty && (out_kind == tlvrp_pkg::KIND_ERROR);

  `TLV_ASSERT_IMPL(a_no_q_overflow, clk, rst_n, cmd_valid, !q_full)
  `TLV_ASSERT_NEXT(a_drain_to_empty, clk, rst_n, pop && !empty && q_empty, empty)
  `TLV_ASSERT_IMPL(a_hdr_last, clk, rst_n, hdr_shown, hdr_last_ok)
  `TLV_ASSERT_IMPL(a_err_last, clk, rst_n, err_shown, out_record_last)

endmodule

`default_nettype wire
